/* hw/rtl/tpc_pkg.sv */
// Shared widths, limits and state encodings for the twin prime checker.
// No dependencies; imported by twin_prime_checker.
package tpc_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int PAIR_LIMIT  = 63;
    localparam int COUNT_W     = 6;

    // Trial divisor never exceeds sqrt(2^VALUE_WIDTH) + 2.
    localparam int DIV_W = VALUE_WIDTH / 2 + 1;
    localparam int REM_W = DIV_W + 1;
    localparam int SQ_W  = VALUE_WIDTH + 2;
    localparam int BIT_W = $clog2(VALUE_WIDTH);

    localparam int IN_DATA_W  = 2 * VALUE_WIDTH;
    localparam int OUT_BITS   = 2 * VALUE_WIDTH + 1 + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] PAIR_LIMIT_C = COUNT_W'(PAIR_LIMIT);

    typedef enum logic [6:0] {
        ST_IDLE        = 7'b0000001,
        ST_SCAN        = 7'b0000010,
        ST_PRIME_START = 7'b0000100,
        ST_PRIME_LOOP  = 7'b0001000,
        ST_DIV         = 7'b0010000,
        ST_DECIDE      = 7'b0100000,
        ST_EMIT        = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        PH_CHK_A   = 2'd0,
        PH_CHK_B   = 2'd1,
        PH_SCAN_LO = 2'd2,
        PH_SCAN_HI = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        RK_CHECK   = 2'd0,
        RK_PAIR    = 2'd1,
        RK_SUMMARY = 2'd2
    } result_kind_t;

    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_SCAN  = 1'b1;

endpackage

/* hw/rtl/twin_prime_checker.sv */
// Twin prime checker: sequencer around one shared bit-serial remainder unit.
// Depends on tpc_pkg for widths, limits and state encodings.
//
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata/s_tuser): one transaction per
//   command. s_tuser selects check (0) or range scan (1); s_tdata carries
//   the two values. Output stream (m_tvalid/m_tready/m_tdata/m_tlast):
//   a check gives one transaction with the twin flag; a scan gives one
//   transaction per twin pair found, then a summary with the count and
//   m_tlast set. cfg_we/cfg_wdata write max_pairs (reset value 63).
//   Throughput: one command at a time. Each primality test runs trial
//   division on a single remainder unit that retires one dividend bit per
//   cycle, trying up to about 128 odd divisors per 16-bit value. A check
//   tests at most two values; a scan tests the candidate pairs n, n+2 that
//   fit in the range, up to the pair limit.
//   Reset (rst_n low) returns the sequencer to idle, drops any pending
//   output and restores max_pairs to 63.
//   When the receiver stalls, the last result holds in the output register;
//   the sequencer may accept a new command meanwhile but holds at its next
//   result until the register frees up.
module twin_prime_checker
    import tpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [COUNT_W-1:0]    cfg_wdata,     // max_pairs
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,       // first_value, second_value
    input  logic                  s_tuser,       // command
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,       // pair_low, pair_high, is_twin,
                                                 // pair_count, zero pad
    output logic                  m_tlast        // last
);

    // configuration register
    logic [COUNT_W-1:0] max_pairs_reg;

    // sequencer
    state_t       state_reg, state_next;
    phase_t       phase_reg, phase_next;
    result_kind_t kind_reg, kind_next;

    // operands and scan state
    logic [VALUE_WIDTH-1:0] val_b_reg, val_b_next;
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   twin_reg, twin_next;

    // primality unit
    logic [VALUE_WIDTH-1:0] cand_reg, cand_next;
    logic [DIV_W-1:0]       d_reg, d_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [DIV_W-1:0]       rem_reg, rem_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic                   prime_reg, prime_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_lo_reg, out_lo_next;
    logic [VALUE_WIDTH-1:0] out_hi_reg, out_hi_next;
    logic                   out_twin_reg, out_twin_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;
    logic                   out_last_reg, out_last_next;

    logic [VALUE_WIDTH-1:0] in_a, in_b;
    logic [VALUE_WIDTH:0]   a_plus2, b_plus2, n_plus2;
    logic [COUNT_W-1:0]     limit;
    logic [REM_W-1:0]       rem_shift, rem_diff;
    logic                   rem_ge;
    logic                   out_free;

    assign in_a = s_tdata[VALUE_WIDTH-1:0];
    assign in_b = s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];

    assign a_plus2 = {1'b0, in_a} + (VALUE_WIDTH+1)'(2);
    assign b_plus2 = {1'b0, in_b} + (VALUE_WIDTH+1)'(2);
    assign n_plus2 = {1'b0, n_reg} + (VALUE_WIDTH+1)'(2);

    assign limit = (max_pairs_reg < PAIR_LIMIT_C) ? max_pairs_reg : PAIR_LIMIT_C;

    // one restoring remainder step: shift in the next dividend bit
    assign rem_shift = {rem_reg, cand_reg[bit_reg]};
    assign rem_ge    = rem_shift >= {1'b0, d_reg};
    assign rem_diff  = rem_shift - {1'b0, d_reg};

    assign out_free = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_DATA_W'({out_count_reg, out_twin_reg, out_hi_reg, out_lo_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pairs_reg <= COUNT_W'(63);
        end
        else if (cfg_we)
        begin
            max_pairs_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        val_b_next     = val_b_reg;
        n_next         = n_reg;
        count_next     = count_reg;
        twin_next      = twin_reg;
        cand_next      = cand_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        prime_next     = prime_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_lo_next    = out_lo_reg;
        out_hi_next    = out_hi_reg;
        out_twin_next  = out_twin_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    val_b_next = in_b;
                    count_next = '0;
                    if (s_tuser == CMD_SCAN)
                    begin
                        n_next     = in_a;
                        state_next = ST_SCAN;
                    end
                    else if (a_plus2 == {1'b0, in_b} || b_plus2 == {1'b0, in_a})
                    begin
                        cand_next  = in_a;
                        phase_next = PH_CHK_A;
                        state_next = ST_PRIME_START;
                    end
                    else
                    begin
                        // values not two apart: no need to test them
                        twin_next  = 1'b0;
                        kind_next  = RK_CHECK;
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_SCAN:
            begin
                if (n_reg < val_b_reg && count_reg < limit)
                begin
                    if (n_plus2 <= {1'b0, val_b_reg})
                    begin
                        cand_next  = n_reg;
                        phase_next = PH_SCAN_LO;
                        state_next = ST_PRIME_START;
                    end
                    else
                    begin
                        n_next = n_reg + VALUE_WIDTH'(1);
                    end
                end
                else
                begin
                    kind_next  = RK_SUMMARY;
                    state_next = ST_EMIT;
                end
            end

            ST_PRIME_START:
            begin
                d_next  = DIV_W'(3);
                sq_next = SQ_W'(9);
                if (cand_reg < VALUE_WIDTH'(2))
                begin
                    prime_next = 1'b0;
                    state_next = ST_DECIDE;
                end
                else if (cand_reg == VALUE_WIDTH'(2))
                begin
                    prime_next = 1'b1;
                    state_next = ST_DECIDE;
                end
                else if (!cand_reg[0])
                begin
                    prime_next = 1'b0;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_PRIME_LOOP;
                end
            end

            ST_PRIME_LOOP:
            begin
                if (sq_reg > SQ_W'(cand_reg))
                begin
                    prime_next = 1'b1;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    rem_next   = '0;
                    bit_next   = BIT_W'(VALUE_WIDTH - 1);
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next = rem_ge ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0)
                begin
                    if (rem_next == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        // advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
                        sq_next    = sq_reg + SQ_W'({d_reg, 2'b00}) + SQ_W'(4);
                        d_next     = d_reg + DIV_W'(2);
                        state_next = ST_PRIME_LOOP;
                    end
                end
            end

            ST_DECIDE:
            begin
                case (phase_reg)
                    PH_CHK_A:
                    begin
                        if (prime_reg)
                        begin
                            cand_next  = val_b_reg;
                            phase_next = PH_CHK_B;
                            state_next = ST_PRIME_START;
                        end
                        else
                        begin
                            twin_next  = 1'b0;
                            kind_next  = RK_CHECK;
                            state_next = ST_EMIT;
                        end
                    end
                    PH_CHK_B:
                    begin
                        twin_next  = prime_reg;
                        kind_next  = RK_CHECK;
                        state_next = ST_EMIT;
                    end
                    PH_SCAN_LO:
                    begin
                        if (prime_reg)
                        begin
                            cand_next  = n_plus2[VALUE_WIDTH-1:0];
                            phase_next = PH_SCAN_HI;
                            state_next = ST_PRIME_START;
                        end
                        else
                        begin
                            n_next     = n_reg + VALUE_WIDTH'(1);
                            state_next = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        if (prime_reg)
                        begin
                            count_next = count_reg + COUNT_W'(1);
                            kind_next  = RK_PAIR;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            n_next     = n_reg + VALUE_WIDTH'(1);
                            state_next = ST_SCAN;
                        end
                    end
                endcase
            end

            ST_EMIT:
            begin
                // hold here until the output register can take the result
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    case (kind_reg)
                        RK_PAIR:
                        begin
                            out_lo_next   = n_reg;
                            out_hi_next   = n_plus2[VALUE_WIDTH-1:0];
                            out_twin_next = 1'b1;
                            out_last_next = 1'b0;
                            n_next        = n_reg + VALUE_WIDTH'(1);
                            state_next    = ST_SCAN;
                        end
                        RK_SUMMARY:
                        begin
                            out_lo_next   = '0;
                            out_hi_next   = '0;
                            out_twin_next = 1'b0;
                            out_last_next = 1'b1;
                            state_next    = ST_IDLE;
                        end
                        default:
                        begin
                            out_lo_next    = '0;
                            out_hi_next    = '0;
                            out_twin_next  = twin_reg;
                            out_count_next = '0;
                            out_last_next  = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        phase_reg     <= phase_next;
        kind_reg      <= kind_next;
        val_b_reg     <= val_b_next;
        n_reg         <= n_next;
        count_reg     <= count_next;
        twin_reg      <= twin_next;
        cand_reg      <= cand_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        rem_reg       <= rem_next;
        bit_reg       <= bit_next;
        prime_reg     <= prime_next;
        out_lo_reg    <= out_lo_next;
        out_hi_reg    <= out_hi_next;
        out_twin_reg  <= out_twin_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for twin_prime_checker: a directed stimulus table, then
// random check and scan commands, every result checked against a typed-in or predicted value.
// Depends on tpc_pkg and the twin_prime_checker RTL.
module tb;
    import tpc_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 40;
    localparam int SETTLE      = 50;
    localparam int REPORT_MAX  = 10;
    localparam int DIRECTED_N  = 24;

    localparam logic [COUNT_W-1:0] MAX_PAIRS_RESET = 6'd63;

    // One output transaction, split into its fields.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] pair_low;
        logic [VALUE_WIDTH-1:0] pair_high;
        logic                   is_twin;
        logic [COUNT_W-1:0]     pair_count;
        logic                   last;
    } twin_result_t;

    // Directed row: optional max_pairs write, one command, and, for single-result
    // rows whose answer is obvious, the typed-in flag or count.
    typedef struct packed {
        logic                   set_limit;
        logic [COUNT_W-1:0]     limit;
        logic                   command;
        logic [VALUE_WIDTH-1:0] first_value;
        logic [VALUE_WIDTH-1:0] second_value;
        logic                   typed;
        logic                   twin;
        logic [COUNT_W-1:0]     count;
    } stim_row_t;

    localparam stim_row_t DIRECTED [DIRECTED_N] = '{
        // values below two, even values, order of the pair, gap of one
        '{1'b0, 6'd0,  CMD_CHECK, 16'd0,     16'd2,     1'b1, 1'b0, 6'd0},
        '{1'b0, 6'd0,  CMD_CHECK, 16'd1,     16'd3,     1'b1, 1'b0, 6'd0},
        '{1'b0, 6'd0,  CMD_CHECK, 16'd2,     16'd4,     1'b1, 1'b0, 6'd0},
        '{1'b0, 6'd0,  CMD_CHECK, 16'd3,     16'd5,     1'b1, 1'b1, 6'd0},
        '{1'b0, 6'd0,  CMD_CHECK, 16'd5,     16'd3,     1'b1, 1'b1, 6'd0},
        '{1'b0, 6'd0,  CMD_CHECK, 16'd2,     16'd3,     1'b1, 1'b0, 6'd0},
        // odd composites, exact squares where divisor squared equals the value
        '{1'b0, 6'd0,  CMD_CHECK, 16'd9,     16'd11,    1'b1, 1'b0, 6'd0},
        '{1'b0, 6'd0,  CMD_CHECK, 16'd25,    16'd27,    1'b1, 1'b0, 6'd0},
        '{1'b0, 6'd0,  CMD_CHECK, 16'd169,   16'd171,   1'b1, 1'b0, 6'd0},
        // top of the value range
        '{1'b0, 6'd0,  CMD_CHECK, 16'd65535, 16'd65533, 1'b0, 1'b0, 6'd0},
        '{1'b0, 6'd0,  CMD_CHECK, 16'd65519, 16'd65521, 1'b0, 1'b0, 6'd0},
        '{1'b0, 6'd0,  CMD_CHECK, 16'd65535, 16'd65535, 1'b1, 1'b0, 6'd0},
        '{1'b0, 6'd0,  CMD_CHECK, 16'd0,     16'd65535, 1'b1, 1'b0, 6'd0},
        '{1'b0, 6'd0,  CMD_CHECK, 16'd32768, 16'd32770, 1'b1, 1'b0, 6'd0},
        // empty and reversed ranges, pair that overruns the end
        '{1'b0, 6'd0,  CMD_SCAN,  16'd0,     16'd0,     1'b1, 1'b0, 6'd0},
        '{1'b0, 6'd0,  CMD_SCAN,  16'd100,   16'd50,    1'b1, 1'b0, 6'd0},
        '{1'b0, 6'd0,  CMD_SCAN,  16'd65535, 16'd0,     1'b1, 1'b0, 6'd0},
        '{1'b0, 6'd0,  CMD_SCAN,  16'd3,     16'd4,     1'b1, 1'b0, 6'd0},
        '{1'b0, 6'd0,  CMD_SCAN,  16'd0,     16'd5,     1'b0, 1'b0, 6'd0},
        // reset limit, limit of one, zero limit, full limit reached
        '{1'b0, 6'd0,  CMD_SCAN,  16'd0,     16'd200,   1'b0, 1'b0, 6'd0},
        '{1'b1, 6'd1,  CMD_SCAN,  16'd0,     16'd200,   1'b0, 1'b0, 6'd0},
        '{1'b1, 6'd0,  CMD_SCAN,  16'd0,     16'd200,   1'b1, 1'b0, 6'd0},
        '{1'b1, 6'd63, CMD_SCAN,  16'd0,     16'd3000,  1'b0, 1'b0, 6'd0},
        '{1'b0, 6'd0,  CMD_SCAN,  16'd65400, 16'd65535, 1'b0, 1'b0, 6'd0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [COUNT_W-1:0]    cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // first_value, second_value
    logic                  s_tuser;   // command
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // pair_low, pair_high, is_twin, pair_count, pad
    logic                  m_tlast;   // last

    twin_result_t       awaited_results[$];
    logic [COUNT_W-1:0] max_pairs_shadow;
    int                 mismatches;
    int                 cycle_count;
    bit                 quiet;      // no idling on either side
    bit                 hold_req;   // ask the receiver for one long hold-off

    twin_prime_checker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Trial division: below two is not prime, two is, other evens are not,
    // then odd divisors from three while the divisor squared fits in the value.
    function automatic bit prime_by_division(input int unsigned v);
        int unsigned d;
        if (v < 2) return 1'b0;
        if (v == 2) return 1'b1;
        if (v[0] == 1'b0) return 1'b0;
        for (d = 3; d * d <= v; d += 2)
            if (v % d == 0) return 1'b0;
        return 1'b1;
    endfunction

    // Queue up every result that one command produces.
    task automatic predict_twins(input logic cmd, input logic [VALUE_WIDTH-1:0] a,
                                 input logic [VALUE_WIDTH-1:0] b);
        twin_result_t r;
        int unsigned  ua, ub, n, limit, found;
        ua = 32'(a);
        ub = 32'(b);
        r  = '0;
        if (cmd == CMD_CHECK)
        begin
            r.is_twin = prime_by_division(ua) && prime_by_division(ub) &&
                        (ua + 2 == ub || ub + 2 == ua);
            r.last    = 1'b1;
            awaited_results.push_back(r);
        end
        else
        begin
            limit = (max_pairs_shadow < PAIR_LIMIT_C) ? 32'(max_pairs_shadow)
                                                      : 32'(PAIR_LIMIT);
            found = 0;
            for (n = ua; n < ub && found < limit; n++)
            begin
                if (n + 2 <= ub && prime_by_division(n) && prime_by_division(n + 2))
                begin
                    found++;
                    r            = '0;
                    r.pair_low   = n[VALUE_WIDTH-1:0];
                    r.pair_high  = VALUE_WIDTH'(n + 2);
                    r.is_twin    = 1'b1;
                    r.pair_count = found[COUNT_W-1:0];
                    awaited_results.push_back(r);
                end
            end
            r            = '0;
            r.pair_count = found[COUNT_W-1:0];
            r.last       = 1'b1;
            awaited_results.push_back(r);
        end
    endtask

    // Offer one command, after a random gap, and return at the edge that takes it.
    task automatic send_command(input logic cmd, input logic [VALUE_WIDTH-1:0] a,
                                input logic [VALUE_WIDTH-1:0] b);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {b, a};
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid and hold until every awaited result has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_max_pairs(input logic [COUNT_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we           <= 1'b0;
        max_pairs_shadow  = v;
    endtask

    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return VALUE_WIDTH'($urandom_range(0, 1023));
        if (sel < 85) return VALUE_WIDTH'($urandom_range(0, 8191));
        return VALUE_WIDTH'($urandom);
    endfunction

    // Mostly well-formed: candidate pairs around real twins and narrow scans over
    // small values; the rest wide, high or reversed.
    task automatic random_command();
        logic                   cmd;
        logic [VALUE_WIDTH-1:0] a, b;
        int unsigned            sel, span, n;
        cmd = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 99);
        if (cmd == CMD_CHECK)
        begin
            if (sel < 30)
            begin
                // advance to the next real twin pair
                n = $urandom_range(0, 4000);
                while (!(prime_by_division(n) && prime_by_division(n + 2))) n++;
                a = VALUE_WIDTH'(n);
                b = VALUE_WIDTH'(n + 2);
                if ($urandom_range(0, 1))
                begin
                    a = VALUE_WIDTH'(n + 2);
                    b = VALUE_WIDTH'(n);
                end
            end
            else if (sel < 65)
            begin
                a = pick_value();
                b = $urandom_range(0, 1) ? a + VALUE_WIDTH'(2) : a - VALUE_WIDTH'(2);
            end
            else if (sel < 85)
            begin
                a = pick_value();
                b = pick_value();
            end
            else
            begin
                a = VALUE_WIDTH'($urandom);
                b = VALUE_WIDTH'($urandom);
            end
        end
        else
        begin
            if (sel < 65)
            begin
                a    = VALUE_WIDTH'($urandom_range(0, 1023));
                span = $urandom_range(0, 40);
            end
            else if (sel < 75)
            begin
                a    = VALUE_WIDTH'($urandom_range(0, 1023));
                span = $urandom_range(41, 160);
            end
            else if (sel < 87)
            begin
                a    = VALUE_WIDTH'($urandom);
                span = $urandom_range(0, 12);
            end
            else
            begin
                a    = VALUE_WIDTH'($urandom_range(0, 16383));
                span = $urandom_range(0, 40);
            end
            b = a + VALUE_WIDTH'(span);
            if ($urandom_range(0, 9) == 0)
                b = a - VALUE_WIDTH'($urandom_range(0, 32'(a)));
        end
        send_command(cmd, a, b);
        predict_twins(cmd, a, b);
    endtask

    // Stimulus: reset, directed table, then random phases under changing limits.
    initial
    begin
        twin_result_t r;
        stim_row_t    row;
        int           p, k;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = CMD_CHECK;
        quiet            = 1'b0;
        hold_req         = 1'b0;
        max_pairs_shadow = MAX_PAIRS_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIRECTED_N; k++)
        begin
            row = DIRECTED[k];
            if (row.set_limit)
                write_max_pairs(row.limit);
            send_command(row.command, row.first_value, row.second_value);
            if (row.typed)
            begin
                r            = '0;
                r.is_twin    = row.twin;
                r.pair_count = row.count;
                r.last       = 1'b1;
                awaited_results.push_back(r);
            end
            else
                predict_twins(row.command, row.first_value, row.second_value);
        end

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       write_max_pairs(6'd1);
                1:       write_max_pairs(6'd63);
                2:       write_max_pairs(6'd0);
                default: write_max_pairs(COUNT_W'($urandom_range(2, 62)));
            endcase
            // idle-free stretch mid-run, and none at all in the closing phase
            quiet = (p == 3 || p == PHASES - 1);
            // long receiver hold-off while commands keep coming: fill up, stall input
            if (p == 1)
                hold_req = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 4 && k == PHASE_ITEMS / 2)
                    wait_drained();
                random_command();
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("** twin_prime_checker: PASSED **");
        else
            $display("** twin_prime_checker: FAILED **");
        $finish;
    end

    // Receiver: random stall bursts, plus one long hold-off counted here.
    initial
    begin
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                idle_left = $urandom_range(1, 15) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Check each output transaction against the oldest awaited result.
    always @(posedge clk)
    begin
        twin_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.pair_low   = m_tdata[VALUE_WIDTH-1:0];
            got.pair_high  = m_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
            got.is_twin    = m_tdata[2*VALUE_WIDTH];
            got.pair_count = m_tdata[2*VALUE_WIDTH+COUNT_W:2*VALUE_WIDTH+1];
            got.last       = m_tlast;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result with nothing awaited: low=%0d high=%0d %s",
                             $realtime, got.pair_low, got.pair_high,
                             $sformatf("twin=%0d cnt=%0d last=%0d",
                                       got.is_twin, got.pair_count, got.last));
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.pair_low !== want.pair_low || got.pair_high !== want.pair_high ||
                    got.is_twin !== want.is_twin || got.pair_count !== want.pair_count ||
                    got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("%0t: mismatch (expected / actual)", $realtime);
                        $display("  pair_low   %0d / %0d", want.pair_low, got.pair_low);
                        $display("  pair_high  %0d / %0d", want.pair_high, got.pair_high);
                        $display("  is_twin    %0d / %0d", want.is_twin, got.is_twin);
                        $display("  pair_count %0d / %0d", want.pair_count, got.pair_count);
                        $display("  last       %0d / %0d", want.last, got.last);
                    end
                end
            end
        end
    end

    initial cycle_count = 0;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Hard stop if the run hangs.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** twin_prime_checker: FAILED **");
        $finish;
    end

endmodule

/* twin_prime_checker.f */
hw/rtl/tpc_pkg.sv
hw/rtl/twin_prime_checker.sv
tb/tb.sv
